// ===== design/hwck_pkg.sv =====
// Shared types and constants for the hue window color keep block.
package hwck_pkg;

  // Hue circle in 1/64 degree units.
  parameter logic [15:0] HUE_FULL  = 16'd23040;
  parameter logic [15:0] HUE_HALF  = 16'd11520;
  parameter logic [15:0] HUE_SIXTH = 16'd3840;

  // Number of register stages from input to the result register.
  parameter int NSTG = 6;

  // Quotient bits resolved by each of the three divider stages.
  parameter int DIV_STEPS = 4;

  // Configuration register indexes (byte address / 4).
  typedef enum logic [2:0] {
    REG_CENTRE_HUE   = 3'd0,
    REG_HALF_WIDTH   = 3'd1,
    REG_WEIGHT_RED   = 3'd2,
    REG_WEIGHT_GREEN = 3'd3,
    REG_WEIGHT_BLUE  = 3'd4
  } reg_idx_t;

  // Which component holds the maximum (ties prefer red, then green).
  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sect_t;

  // Current configuration.
  typedef struct packed {
    logic [14:0] centre_hue;
    logic [13:0] half_width;
    logic [8:0]  weight_red;
    logic [8:0]  weight_green;
    logic [8:0]  weight_blue;
  } cfg_t;

  // Payload carried through the front stage and the divider stages.
  // work holds {partial remainder, dividend bits / quotient bits}.
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  divisor;
    logic        neg;
    sect_t       sect;
    logic        flat;
    logic [19:0] work;
    logic [16:0] prod_r;
    logic [16:0] prod_g;
    logic [16:0] prod_b;
  } pipe_t;

  // Final result fields.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       keep;
  } res_t;

endpackage

// ===== design/hwck_pix_if.sv =====
// Input pixel channel: valid/ready handshake with RGB payload.
interface hwck_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

// ===== design/hwck_res_if.sv =====
// Result pixel channel: valid/ready handshake with RGB and window flag.
interface hwck_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       in_window;

  modport source (output valid, red_out, green_out, blue_out, in_window, input ready);
  modport sink (input valid, red_out, green_out, blue_out, in_window, output ready);
endinterface

// ===== design/hue_window_color_keep.sv =====
// Top level of the hue window color keep filter.
// Throughput: one pixel per cycle while the result side takes results;
// the three-stage long divider for the hue ratio sets the pipeline depth,
// four quotient bits per stage. Each stage holds an item while the next
// is full, so bubbles fill in.
// Reset clears all stage valid bits and restores the register defaults.
module hue_window_color_keep (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  hwck_pix_if.sink    pixel,
  hwck_res_if.source  result
);

  hwck_pkg::cfg_t         cfg;
  hwck_pkg::pipe_t        p_front;
  hwck_pkg::pipe_t        p_div1;
  hwck_pkg::pipe_t        p_div2;
  hwck_pkg::pipe_t        p_div3;
  hwck_pkg::res_t         res;
  logic [hwck_pkg::NSTG-1:0] vld;
  logic [hwck_pkg::NSTG-1:0] adv;

  hwck_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    adv[hwck_pkg::NSTG-1] = !vld[hwck_pkg::NSTG-1] || result.ready;
    for (int i = hwck_pkg::NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign pixel.ready = adv[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < hwck_pkg::NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= (i == 0) ? pixel.valid : vld[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  hwck_front u_front (
    .clk   (clk),
    .en    (adv[0]),
    .red   (pixel.red_in),
    .green (pixel.green_in),
    .blue  (pixel.blue_in),
    .cfg   (cfg),
    .pout  (p_front)
  );

  hwck_div_stage u_div1 (.clk(clk), .en(adv[1]), .pin(p_front), .pout(p_div1));
  hwck_div_stage u_div2 (.clk(clk), .en(adv[2]), .pin(p_div1),  .pout(p_div2));
  hwck_div_stage u_div3 (.clk(clk), .en(adv[3]), .pin(p_div2),  .pout(p_div3));

  hwck_window u_window (
    .clk    (clk),
    .en_hue (adv[4]),
    .en_out (adv[5]),
    .pin    (p_div3),
    .cfg    (cfg),
    .res    (res)
  );

  assign result.valid     = vld[hwck_pkg::NSTG-1];
  assign result.red_out   = res.red;
  assign result.green_out = res.green;
  assign result.blue_out  = res.blue;
  assign result.in_window = res.keep;

  // A pixel outside the window leaves as one gray level on all channels.
  a_gray_equal: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.in_window) |->
      (result.red_out == result.green_out) && (result.green_out == result.blue_out))
    else $error("gray result channels differ");

  // An accepted pixel occupies the first stage on the next cycle.
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready) |=> vld[0])
    else $error("accepted pixel lost at first stage");

  // Input back-pressure only when every stage is full.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> (&vld))
    else $error("input stalled with a free stage");

endmodule

// ===== design/hwck_cfg.sv =====
// APB configuration registers for the hue window and gray weights.
module hwck_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output hwck_pkg::cfg_t   cfg
);

  hwck_pkg::reg_idx_t idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = hwck_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centre_hue   <= 15'd0;
      cfg.half_width   <= 14'd1920;
      cfg.weight_red   <= 9'd77;
      cfg.weight_green <= 9'd150;
      cfg.weight_blue  <= 9'd29;
    end else if (wr) begin
      unique case (idx)
        hwck_pkg::REG_CENTRE_HUE:   cfg.centre_hue   <= pwdata[14:0];
        hwck_pkg::REG_HALF_WIDTH:   cfg.half_width   <= pwdata[13:0];
        hwck_pkg::REG_WEIGHT_RED:   cfg.weight_red   <= pwdata[8:0];
        hwck_pkg::REG_WEIGHT_GREEN: cfg.weight_green <= pwdata[8:0];
        hwck_pkg::REG_WEIGHT_BLUE:  cfg.weight_blue  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx)
      hwck_pkg::REG_CENTRE_HUE:   prdata = {17'd0, cfg.centre_hue};
      hwck_pkg::REG_HALF_WIDTH:   prdata = {18'd0, cfg.half_width};
      hwck_pkg::REG_WEIGHT_RED:   prdata = {23'd0, cfg.weight_red};
      hwck_pkg::REG_WEIGHT_GREEN: prdata = {23'd0, cfg.weight_green};
      hwck_pkg::REG_WEIGHT_BLUE:  prdata = {23'd0, cfg.weight_blue};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/hwck_front.sv =====
// First stage: max/min, sector, hue numerator and gray products.
module hwck_front (
  input  logic            clk,
  input  logic            en,
  input  logic [7:0]      red,
  input  logic [7:0]      green,
  input  logic [7:0]      blue,
  input  hwck_pkg::cfg_t  cfg,
  output hwck_pkg::pipe_t pout
);

  logic [7:0]        mx;
  logic [7:0]        mn;
  logic signed [8:0] num;
  logic [7:0]        abs_num;
  hwck_pkg::sect_t   sect;
  hwck_pkg::pipe_t   pnext;

  // Maximum, minimum and which channel wins the maximum.
  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    if (red == mx) begin
      sect = hwck_pkg::SECT_RED;
      num  = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green == mx) begin
      sect = hwck_pkg::SECT_GREEN;
      num  = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sect = hwck_pkg::SECT_BLUE;
      num  = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    abs_num = num[8] ? 8'(-num) : num[7:0];
  end

  // Assemble the payload; the dividend is |n| * 3840 = |n|*4096 - |n|*256.
  always_comb begin
    pnext.red     = red;
    pnext.green   = green;
    pnext.blue    = blue;
    pnext.divisor = mx - mn;
    pnext.neg     = num[8];
    pnext.sect    = sect;
    pnext.flat    = (mx == mn);
    pnext.work    = {abs_num, 12'd0} - {4'd0, abs_num, 8'd0};
    pnext.prod_r  = 17'(cfg.weight_red * red);
    pnext.prod_g  = 17'(cfg.weight_green * green);
    pnext.prod_b  = 17'(cfg.weight_blue * blue);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pout <= pnext;
    end
  end

endmodule

// ===== design/hwck_div_stage.sv =====
// One divider stage: four restoring long-division steps on the hue ratio.
module hwck_div_stage (
  input  logic            clk,
  input  logic            en,
  input  hwck_pkg::pipe_t pin,
  output hwck_pkg::pipe_t pout
);

  hwck_pkg::pipe_t pnext;
  logic [19:0]     w;
  logic [8:0]      t;
  logic            qb;

  // Shift the next dividend bit into the remainder, subtract when it fits,
  // and shift the quotient bit in at the bottom.
  always_comb begin
    pnext = pin;
    w     = pin.work;
    for (int i = 0; i < hwck_pkg::DIV_STEPS; i++) begin
      t  = {w[19:12], w[11]};
      qb = (t >= {1'b0, pin.divisor});
      if (qb) t = t - {1'b0, pin.divisor};
      w = {t[7:0], w[10:0], qb};
    end
    pnext.work = w;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pout <= pnext;
    end
  end

endmodule

// ===== design/hwck_window.sv =====
// Last two stages: hue assembly and gray sum, then window test and select.
module hwck_window (
  input  logic            clk,
  input  logic            en_hue,
  input  logic            en_out,
  input  hwck_pkg::pipe_t pin,
  input  hwck_pkg::cfg_t  cfg,
  output hwck_pkg::res_t  res
);

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] hue;
    logic [18:0] gray_sum;
    logic [14:0] centre;
    logic [13:0] half;
  } hue_t;

  hue_t               hnext;
  hue_t               hreg;
  logic signed [16:0] base;
  logic signed [16:0] qs;
  logic signed [16:0] hsum;
  logic [15:0]        gap_raw;
  logic [15:0]        gap;
  logic               keep;
  logic [7:0]         gray;
  hwck_pkg::res_t     rnext;

  // Hue = sector base +/- quotient, wrapped into one turn.
  always_comb begin
    unique case (pin.sect)
      hwck_pkg::SECT_RED:   base = 17'sd0;
      hwck_pkg::SECT_GREEN: base = $signed({1'b0, hwck_pkg::HUE_SIXTH << 1});
      hwck_pkg::SECT_BLUE:  base = $signed({1'b0, hwck_pkg::HUE_SIXTH << 2});
      default:              base = 17'sd0;
    endcase
    qs   = pin.neg ? -$signed({5'd0, pin.work[11:0]}) : $signed({5'd0, pin.work[11:0]});
    hsum = base + qs;
    if (hsum < 0) hsum = hsum + $signed({1'b0, hwck_pkg::HUE_FULL});

    hnext.red      = pin.red;
    hnext.green    = pin.green;
    hnext.blue     = pin.blue;
    hnext.hue      = pin.flat ? 15'd0 : hsum[14:0];
    hnext.gray_sum = {2'b00, pin.prod_r} + {2'b00, pin.prod_g} + {2'b00, pin.prod_b};
    // Centre reduced into one turn, half width capped at half a turn.
    hnext.centre   = ({1'b0, cfg.centre_hue} >= hwck_pkg::HUE_FULL)
                     ? 15'({1'b0, cfg.centre_hue} - hwck_pkg::HUE_FULL)
                     : cfg.centre_hue;
    hnext.half     = ({2'b00, cfg.half_width} > hwck_pkg::HUE_HALF)
                     ? hwck_pkg::HUE_HALF[13:0] : cfg.half_width;
  end

  always_ff @(posedge clk) begin
    if (en_hue) begin
      hreg <= hnext;
    end
  end

  // Circular distance from the centre and the window test.
  always_comb begin
    gap_raw = {1'b0, hreg.hue} + hwck_pkg::HUE_FULL - {1'b0, hreg.centre};
    gap     = (gap_raw >= hwck_pkg::HUE_FULL) ? gap_raw - hwck_pkg::HUE_FULL : gap_raw;
    keep    = (gap <= {2'b00, hreg.half})
              || (gap >= hwck_pkg::HUE_FULL - {2'b00, hreg.half});
    gray    = (hreg.gray_sum[18:16] != 3'd0) ? 8'hFF : hreg.gray_sum[15:8];

    rnext.keep  = keep;
    rnext.red   = keep ? hreg.red   : gray;
    rnext.green = keep ? hreg.green : gray;
    rnext.blue  = keep ? hreg.blue  : gray;
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      res <= rnext;
    end
  end

endmodule

// ===== dv/hwck_color_keep_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts and compares every result transaction of the hue window color keep block.
module hwck_color_keep_checker
  import hwck_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  hwck_pix_if         pixel,
  hwck_res_if         result,
  output int          failures,
  output int          outstanding
);

  cfg_t cfg_shadow;
  res_t expected_pixels[$];

  // Hue in 1/64 degree; ties for the maximum go to red, then green.
  function automatic int hue_of(int r, int g, int b);
    int peak, lowest, span, num, offset, h;
    peak = r;
    lowest = r;
    if (g > peak) peak = g;
    if (b > peak) peak = b;
    if (g < lowest) lowest = g;
    if (b < lowest) lowest = b;
    span = peak - lowest;
    if (span == 0) return 0;
    if (r == peak) begin
      num = g - b;
      offset = 0;
    end else if (g == peak) begin
      num = b - r;
      offset = 2 * int'(HUE_SIXTH);
    end else begin
      num = r - g;
      offset = 4 * int'(HUE_SIXTH);
    end
    // Signed division truncates toward zero; negative hues wrap once.
    h = offset + (int'(HUE_SIXTH) * num) / span;
    if (h < 0) h += int'(HUE_FULL);
    return h;
  endfunction

  // Keeps the pixel when its hue lies in the window, else turns it gray.
  function automatic res_t kept_or_gray(cfg_t c, int r, int g, int b);
    int hue, centre, reach, gap, gray;
    res_t res;
    hue = hue_of(r, g, b);
    centre = int'(c.centre_hue) % int'(HUE_FULL);
    reach = (c.half_width > HUE_HALF) ? int'(HUE_HALF) : int'(c.half_width);
    gap = (hue + int'(HUE_FULL) - centre) % int'(HUE_FULL);
    res.keep = (gap <= reach) || (gap >= int'(HUE_FULL) - reach);
    if (res.keep) begin
      res.red = r[7:0];
      res.green = g[7:0];
      res.blue = b[7:0];
    end else begin
      gray = (int'(c.weight_red) * r + int'(c.weight_green) * g
              + int'(c.weight_blue) * b) >> 8;
      if (gray > 255) gray = 255;
      res.red = gray[7:0];
      res.green = gray[7:0];
      res.blue = gray[7:0];
    end
    return res;
  endfunction

  // Track register writes, queue predictions and compare results in order.
  always @(posedge clk) begin : track
    res_t want;
    if (rst) begin
      cfg_shadow <= '{centre_hue: 15'd0, half_width: 14'd1920, weight_red: 9'd77,
                      weight_green: 9'd150, weight_blue: 9'd29};
      expected_pixels.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_CENTRE_HUE:   cfg_shadow.centre_hue <= pwdata[14:0];
          REG_HALF_WIDTH:   cfg_shadow.half_width <= pwdata[13:0];
          REG_WEIGHT_RED:   cfg_shadow.weight_red <= pwdata[8:0];
          REG_WEIGHT_GREEN: cfg_shadow.weight_green <= pwdata[8:0];
          REG_WEIGHT_BLUE:  cfg_shadow.weight_blue <= pwdata[8:0];
          default: ;
        endcase
      end

      if (pixel.valid && pixel.ready) begin
        expected_pixels.push_back(kept_or_gray(cfg_shadow, pixel.red_in,
                                               pixel.green_in, pixel.blue_in));
      end

      if (result.valid && result.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result transaction with no pixel pending");
          failures++;
        end else begin
          want = expected_pixels.pop_front();
          if (result.red_out !== want.red) begin
            $error("red_out mismatch: expected %0d, actual %0d", want.red, result.red_out);
            failures++;
          end
          if (result.green_out !== want.green) begin
            $error("green_out mismatch: expected %0d, actual %0d",
                   want.green, result.green_out);
            failures++;
          end
          if (result.blue_out !== want.blue) begin
            $error("blue_out mismatch: expected %0d, actual %0d", want.blue, result.blue_out);
            failures++;
          end
          if (result.in_window !== want.keep) begin
            $error("in_window mismatch: expected %0d, actual %0d",
                   want.keep, result.in_window);
            failures++;
          end
        end
      end
      outstanding <= expected_pixels.size();
    end
  end

endmodule

// ===== dv/tb_hue_window_color_keep.sv =====
`timescale 1ns / 1ps
// Testbench top for the hue window color keep block: stimulus, configuration and verdict.
module tb_hue_window_color_keep;
  import hwck_pkg::*;

  localparam int         CYCLE_LIMIT = 200000;
  localparam int         IDLE_PCT    = 19;
  localparam int         LONG_HOLD   = 400;
  localparam logic [2:0] REG_UNUSED  = 3'd5;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          failures;
  int          outstanding;
  int          cycle_count;
  bit          steady;
  bit          long_hold;

  hwck_pix_if pixel_ch ();
  hwck_res_if result_ch ();

  hue_window_color_keep i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixel   (pixel_ch),
    .result  (result_ch)
  );

  hwck_color_keep_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .pixel       (pixel_ch),
    .result      (result_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random back-pressure, or a long hold-off when requested.
  initial begin : result_sink
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] centre, input logic [31:0] half,
                            input logic [31:0] w_red, input logic [31:0] w_green,
                            input logic [31:0] w_blue);
    write_reg(REG_CENTRE_HUE, centre);
    write_reg(REG_HALF_WIDTH, half);
    write_reg(REG_WEIGHT_RED, w_red);
    write_reg(REG_WEIGHT_GREEN, w_green);
    write_reg(REG_WEIGHT_BLUE, w_blue);
  endtask

  // Offer one pixel, with random gaps ahead of it, and wait for acceptance.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.red_in <= r;
    pixel_ch.green_in <= g;
    pixel_ch.blue_in <= b;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
  endtask

  // Mostly uniform colors, with a share of saturated, tied and gray pixels.
  task automatic send_random_pixel();
    logic [7:0] ch[3];
    int mode;
    mode = $urandom_range(9);
    foreach (ch[i]) ch[i] = $urandom_range(255);
    case (mode)
      6, 7: foreach (ch[i]) if ($urandom_range(1)) ch[i] = $urandom_range(1) ? 8'hFF : 8'h00;
      8: ch[$urandom_range(2)] = ch[$urandom_range(2)];
      9: begin
        ch[1] = ch[0];
        ch[2] = ch[0];
      end
      default: ;
    endcase
    send_pixel(ch[0], ch[1], ch[2]);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (NSTG + 2) @(posedge clk);
  endtask

  task automatic random_phase(input int count, input int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) long_hold = 1'b1;
      send_random_pixel();
    end
    drain();
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pixel_ch.valid <= 1'b0;
    pixel_ch.red_in <= '0;
    pixel_ch.green_in <= '0;
    pixel_ch.blue_in <= '0;
    steady = 1'b0;
    long_hold = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset window: primaries, ties, negative hue wrap and window edges.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd200, 8'd100, 8'd0);
    send_pixel(8'd200, 8'd101, 8'd0);
    send_pixel(8'd200, 8'd0, 8'd100);
    send_pixel(8'd200, 8'd0, 8'd101);
    send_pixel(8'd128, 8'd64, 8'd32);
    drain();

    // Top centre, zero width, gray saturating at full scale.
    set_config(32'd23039, 32'd0, 32'd256, 32'd256, 32'd256);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd0, 8'd0);
    random_phase(90, -1);

    // Zero width on pure green: only the exact hue passes.
    set_config(32'd7680, 32'd0, 32'd77, 32'd150, 32'd29);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd1, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd1);
    random_phase(60, -1);

    // All ones on every register: centre out of range, oversize width,
    // largest weights; a stray write to an unused index first. No idling.
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    steady = 1'b1;
    random_phase(80, -1);
    steady = 1'b0;

    // Half circle exactly, zero weights, with a long receiver stall.
    set_config(32'd11520, 32'd11520, 32'd0, 32'd0, 32'd0);
    random_phase(60, 20);

    // Random settings, mostly narrow windows.
    for (int k = 0; k < 5; k++) begin
      set_config($urandom_range(32767),
                 ($urandom_range(2) == 0) ? $urandom_range(16383) : $urandom_range(2500),
                 $urandom_range(511), $urandom_range(511), $urandom_range(511));
      random_phase(60, (k == 2) ? 30 : -1);
    end

    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
